>>> rtl/efw_pkg.sv
`timescale 1ns / 1ps

package efw_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int TIME_BITS   = 48;
  localparam int ID_W        = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
  localparam int CFG_W       = 5;
  localparam int CFG_RESET   = 16;
  localparam int DUR_W       = 32;
  localparam int SUM_W       = ((TIME_BITS > DUR_W) ? TIME_BITS : DUR_W) + 1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [ID_W-1:0]      wid_t;

  typedef struct packed {
    time_t t;
    wid_t  id;
  } elem_t;

  typedef struct packed {
    logic valid;
    logic upd;
    logic below;
    logic at_r;
    logic load;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_INS
  } state_t;

  function automatic logic earlier(elem_t a, elem_t b);
    earlier = (a.t < b.t) || ((a.t == b.t) && (a.id < b.id));
  endfunction

endpackage

>>> rtl/efw_cell.sv
`timescale 1ns / 1ps

module efw_cell (
  input  logic              clk,
  input  efw_pkg::cell_ctl_t ctl,
  input  efw_pkg::elem_t    new_elem,
  input  efw_pkg::elem_t    prev_elem,
  input  logic              prev_lt,
  input  efw_pkg::elem_t    next_elem,
  input  logic              next_lt,
  output efw_pkg::elem_t    elem,
  output logic              lt
);
  import efw_pkg::*;

  elem_t elem_r;
  elem_t elem_nxt;

  assign elem = elem_r;
  assign lt   = ctl.valid && earlier(elem_r, new_elem);

  // Insert shifts later entries right; update removes one entry, closes the gap, inserts new_elem.
  always_comb begin
    elem_nxt = elem_r;
    if (ctl.load) begin
      if (!ctl.upd) begin
        if (lt) begin
          elem_nxt = elem_r;
        end else if (prev_lt) begin
          elem_nxt = new_elem;
        end else begin
          elem_nxt = prev_elem;
        end
      end else begin
        if (ctl.below) begin
          elem_nxt = elem_r;
        end else if (next_lt) begin
          elem_nxt = next_elem;
        end else if (ctl.at_r || lt) begin
          elem_nxt = new_elem;
        end else begin
          elem_nxt = elem_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
  end

endmodule

>>> rtl/earliest_free_worker_dispatch.sv
`timescale 1ns / 1ps
// Accepted beat goes to ST_CALC; the result beat is registered there once the output is free.
// Per job: select, compute new free time, shift the cell chain; only then is another job taken.
// A held result beat stalls the compute step, and no new job is accepted until it completes.
// Reset (rst_n low at a clock edge) empties the batch and sets workers_in_use to 16.
module earliest_free_worker_dispatch (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,   // workers_in_use
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // job_duration
  input  logic [0:0]  in_tuser,      // new_batch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata      // worker [3:0], start_time [51:4], zero [55:52]
);
  import efw_pkg::*;

  state_t state_r, state_nxt;
  logic   calc_go;
  logic   ins_go;

  logic [CFG_W-1:0]       cfg_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       n_eff;
  logic [DUR_W-1:0]       dur_r;
  logic                   start_mode_r;
  logic [MAX_WORKERS-1:0] onehot_r, onehot_c;
  logic [MAX_WORKERS-1:0] below_r, below_c;
  elem_t                  key_r;
  elem_t                  sel_c;

  logic                   out_valid_r;
  logic [3:0]             out_worker_r;
  logic [47:0]            out_time_r;

  elem_t                  elems [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] lts;
  logic [MAX_WORKERS-1:0] valids;

  function automatic time_t sat_add(time_t t, logic [DUR_W-1:0] d);
    logic [SUM_W-1:0] s;
    s = SUM_W'(t) + SUM_W'(d);
    if (s > SUM_W'({TIME_BITS{1'b1}})) begin
      sat_add = {TIME_BITS{1'b1}};
    end else begin
      sat_add = TIME_BITS'(s);
    end
  endfunction

  always_comb begin
    if (cfg_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(cfg_r) > MAX_WORKERS) begin
      n_eff = CNT_W'(MAX_WORKERS);
    end else begin
      n_eff = CNT_W'(cfg_r);
    end
  end

  // First started cell whose worker is still in use.
  always_comb begin
    logic seen;
    logic elig;
    seen = 1'b0;
    for (int k = 0; k < MAX_WORKERS; k++) begin
      elig        = valids[k] && (CNT_W'(elems[k].id) < n_eff);
      onehot_c[k] = elig && !seen;
      below_c[k]  = !seen && !elig;
      seen        = seen || elig;
    end
  end

  always_comb begin
    sel_c = '0;
    for (int k = 0; k < MAX_WORKERS; k++) begin
      if (onehot_r[k]) begin
        sel_c = sel_c | elems[k];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    calc_go   = 1'b0;
    ins_go    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (!out_valid_r || out_tready) begin
          calc_go   = 1'b1;
          state_nxt = ST_INS;
        end
      end
      ST_INS: begin
        ins_go    = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= CFG_W'(CFG_RESET);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (in_tvalid && in_tready && in_tuser[0]) begin
        cnt_r <= '0;
      end else if (ins_go && start_mode_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (calc_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      dur_r        <= in_tdata;
      start_mode_r <= in_tuser[0] || (cnt_r < n_eff);
      onehot_r     <= onehot_c;
      below_r      <= below_c;
    end
    if (calc_go) begin
      if (start_mode_r) begin
        key_r.t      <= sat_add('0, dur_r);
        key_r.id     <= ID_W'(cnt_r);
        out_worker_r <= 4'(cnt_r);
        out_time_r   <= '0;
      end else begin
        key_r.t      <= sat_add(sel_c.t, dur_r);
        key_r.id     <= sel_c.id;
        out_worker_r <= 4'(sel_c.id);
        out_time_r   <= 48'(sel_c.t);
      end
    end
  end

  for (genvar k = 0; k < MAX_WORKERS; k++) begin : g_cell
    cell_ctl_t ctl;
    elem_t     prev_elem;
    logic      prev_lt;
    elem_t     next_elem;
    logic      next_lt;

    assign valids[k] = CNT_W'(k) < cnt_r;

    assign ctl.valid = valids[k];
    assign ctl.upd   = !start_mode_r;
    assign ctl.below = below_r[k];
    assign ctl.at_r  = onehot_r[k];
    assign ctl.load  = ins_go;

    if (k == 0) begin : g_first
      assign prev_elem = key_r;
      assign prev_lt   = 1'b1;
    end else begin : g_mid
      assign prev_elem = elems[k-1];
      assign prev_lt   = lts[k-1];
    end

    if (k == MAX_WORKERS - 1) begin : g_last
      assign next_elem = elems[k];
      assign next_lt   = 1'b0;
    end else begin : g_body
      assign next_elem = elems[k+1];
      assign next_lt   = lts[k+1];
    end

    efw_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_elem  (key_r),
      .prev_elem (prev_elem),
      .prev_lt   (prev_lt),
      .next_elem (next_elem),
      .next_lt   (next_lt),
      .elem      (elems[k]),
      .lt        (lts[k])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_time_r, out_worker_r};

endmodule
